// ===== src/bmprle_pkg.sv =====
`default_nettype none

package bmprle_pkg;

   localparam logic OP_DATA    = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   localparam logic KIND_RUN = 1'b0;
   localparam logic KIND_END = 1'b1;

   typedef struct packed {
      logic        emit;
      logic        kind;
      logic [7:0]  index;
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  length;
   } evt_type;

endpackage

`default_nettype wire

// ===== src/bmprle_parser.sv =====
`default_nettype none

module bmprle_parser import bmprle_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        data_fire,
   input  wire logic [7:0]  data_byte,
   input  wire logic [23:0] image_bytes,
   output evt_type          evt
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int SW = ((CW > 8) ? CW : 8) + 1;

   localparam logic [2:0] PH_COUNT   = 3'd0;
   localparam logic [2:0] PH_VALUE   = 3'd1;
   localparam logic [2:0] PH_ESCAPE  = 3'd2;
   localparam logic [2:0] PH_DX      = 3'd3;
   localparam logic [2:0] PH_DY      = 3'd4;
   localparam logic [2:0] PH_LITERAL = 3'd5;
   localparam logic [2:0] PH_PAD     = 3'd6;

   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [7:0] b);
      logic [SW-1:0] sum;
      sum = SW'(a) + SW'(b);
      return (sum > SW'(MAX_DIM - 1)) ? CW'(MAX_DIM - 1) : sum[CW-1:0];
   endfunction

   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    literal_ff, literal_in;
   logic          pad_ff, pad_in;
   logic [7:0]    dcol_ff, dcol_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [23:0]   seen_ff, seen_in;
   logic          finished_ff, finished_in;

   logic          active;
   logic [CW+11:0] col_ext;
   logic [CW+11:0] row_ext;

   assign active  = data_fire && !finished_ff && (seen_ff < image_bytes);
   assign col_ext = {12'd0, col_ff};
   assign row_ext = {12'd0, row_ff};

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      literal_in  = literal_ff;
      pad_in      = pad_ff;
      dcol_in     = dcol_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      seen_in     = seen_ff;
      finished_in = finished_ff;
      evt.emit    = 1'b0;
      evt.kind    = KIND_RUN;
      evt.index   = data_byte;
      evt.column  = col_ext[11:0];
      evt.row     = row_ext[11:0];
      evt.length  = 8'd1;
      if (active) begin
         seen_in = seen_ff + 24'd1;
         unique case (phase_ff)
            PH_COUNT: begin
               if (data_byte != 8'd0) begin
                  count_in = data_byte;
                  phase_in = PH_VALUE;
               end else begin
                  phase_in = PH_ESCAPE;
               end
            end
            PH_VALUE: begin
               evt.emit   = 1'b1;
               evt.length = count_ff;
               col_in     = sat_add(col_ff, count_ff);
               count_in   = 8'd0;
               phase_in   = PH_COUNT;
            end
            PH_ESCAPE: begin
               case (data_byte)
                  ESC_EOL: begin
                     col_in   = '0;
                     row_in   = sat_add(row_ff, 8'd1);
                     phase_in = PH_COUNT;
                  end
                  ESC_EOB: begin
                     finished_in = 1'b1;
                     phase_in    = PH_COUNT;
                     evt.emit    = 1'b1;
                     evt.kind    = KIND_END;
                     evt.length  = 8'd0;
                  end
                  ESC_DELTA: phase_in = PH_DX;
                  default: begin
                     literal_in = data_byte;
                     pad_in     = data_byte[0];
                     phase_in   = PH_LITERAL;
                  end
               endcase
            end
            PH_DX: begin
               dcol_in  = data_byte;
               phase_in = PH_DY;
            end
            PH_DY: begin
               col_in   = sat_add(col_ff, dcol_ff);
               row_in   = sat_add(row_ff, data_byte);
               dcol_in  = 8'd0;
               phase_in = PH_COUNT;
            end
            PH_LITERAL: begin
               evt.emit   = 1'b1;
               col_in     = sat_add(col_ff, 8'd1);
               literal_in = literal_ff - 8'd1;
               if (literal_ff == 8'd1) begin
                  phase_in = pad_ff ? PH_PAD : PH_COUNT;
                  pad_in   = 1'b0;
               end
            end
            PH_PAD: phase_in = PH_COUNT;
            default: phase_in = PH_COUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COUNT;
         count_ff    <= 8'd0;
         literal_ff  <= 8'd0;
         pad_ff      <= 1'b0;
         dcol_ff     <= 8'd0;
         col_ff      <= '0;
         row_ff      <= '0;
         seen_ff     <= 24'd0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         literal_ff  <= literal_in;
         pad_ff      <= pad_in;
         dcol_ff     <= dcol_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         seen_ff     <= seen_in;
         finished_ff <= finished_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bmp_rle8_pixel_decoder_top.sv =====
// BMP RLE8 decoder: takes one word per cycle, either an encoded stream byte or a
// palette entry write, and returns one word per pixel run (plus one end-of-bitmap
// word). A run word goes from the byte that completes it through the synchronous
// palette read and then the output register. Input stalls only when both the
// palette-read stage and the output register hold words that the output side
// has not taken. Palette contents are undefined after reset until written;
// image_bytes resets to 0, so no byte is decoded until it is set.
`default_nettype none

module bmp_rle8_pixel_decoder_top import bmprle_pkg::*; #(
   parameter int MAX_DIM      = 4096,
   parameter int PALETTE_SIZE = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_palette_index,
   input  wire logic [31:0] req_palette_color,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [11:0]      rsp_column,
   output logic [11:0]      rsp_row,
   output logic [31:0]      rsp_color,
   output logic [7:0]       rsp_run_length,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data
);

   localparam int PAW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   logic [31:0] pal_mem [PALETTE_SIZE];
   logic [31:0] pal_rdata_ff;

   logic [23:0] image_bytes_ff;

   evt_type     evt;
   logic        req_fire;
   logic        pal_wr;
   logic        pal_rd;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff;
   logic        s1_zero_ff;
   logic [11:0] s1_column_ff;
   logic [11:0] s1_row_ff;
   logic [7:0]  s1_length_ff;
   logic        s1_go;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff;
   logic [11:0] out_column_ff;
   logic [11:0] out_row_ff;
   logic [31:0] out_color_ff;
   logic [7:0]  out_length_ff;

   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign pal_wr    = req_fire && (req_opcode == OP_PALETTE) &&
                      ({24'd0, req_palette_index} < 32'(PALETTE_SIZE));
   assign pal_rd    = evt.emit && (evt.kind == KIND_RUN);

   bmprle_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .data_fire   (req_fire && (req_opcode == OP_DATA)),
      .data_byte   (req_data_byte),
      .image_bytes (image_bytes_ff),
      .evt         (evt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         image_bytes_ff <= 24'd0;
      end else if (csr_wr_en) begin
         image_bytes_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[req_palette_index[PAW-1:0]] <= req_palette_color;
      end
      if (pal_rd) begin
         pal_rdata_ff <= pal_mem[evt.index[PAW-1:0]];
      end
   end

   assign s1_go        = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s1_valid_in  = evt.emit || (s1_valid_ff && !s1_go);
   assign out_valid_in = s1_go || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt.emit) begin
         s1_kind_ff   <= evt.kind;
         s1_zero_ff   <= (evt.kind == KIND_END) ||
                         ({24'd0, evt.index} >= 32'(PALETTE_SIZE));
         s1_column_ff <= evt.column;
         s1_row_ff    <= evt.row;
         s1_length_ff <= evt.length;
      end
      if (s1_go) begin
         out_kind_ff   <= s1_kind_ff;
         out_column_ff <= s1_column_ff;
         out_row_ff    <= s1_row_ff;
         out_color_ff  <= s1_zero_ff ? 32'd0 : pal_rdata_ff;
         out_length_ff <= s1_length_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_column     = out_column_ff;
   assign rsp_row        = out_row_ff;
   assign rsp_color      = out_color_ff;
   assign rsp_run_length = out_length_ff;

endmodule

`default_nettype wire

// ===== src/bmprle_checker.sv =====
`default_nettype none

module bmprle_checker import bmprle_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_kind,
   input wire logic [31:0] rsp_color,
   input wire logic [7:0]  rsp_run_length
);

   // end word carries no color and no length
   a_end_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END) |-> (rsp_run_length == 8'd0) && (rsp_color == 32'd0))
      else $error("end word with nonzero color or length");

   // every pixel run covers at least one pixel
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RUN) |-> (rsp_run_length != 8'd0))
      else $error("pixel run of length zero");

   // input backpressure only arises from a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind bmp_rle8_pixel_decoder_top bmprle_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_color      (rsp_color),
   .rsp_run_length (rsp_run_length)
);

`default_nettype wire
